[hdl/wrrs_pkg.sv]
// ----------------------------------------------------------------------------
// wrrs_pkg
// types and helpers shared by the weighted round-robin scheduler modules
// ----------------------------------------------------------------------------
package wrrs_pkg;

	localparam int unsigned MAX_WEIGHT = 64;

	typedef enum logic [1:0] {
		ST_SENT  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ENQ   = 2'd2,
		ST_DROP  = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_SERVE   = 1'b1
	} command_t;

	typedef struct packed {
		command_t    command;
		logic [2:0]  flow_index;
		logic [31:0] packet_id;
		logic [15:0] packet_length;
		logic [6:0]  flow_weight;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] sent_id;
		logic [15:0] sent_length;
		logic [2:0]  sent_flow;
		logic        last_of_run;
	} rsp_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic flow_ok;
		req_t req;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SKIP,
		BK_READ,
		BK_EMIT
	} back_state_t;

	function automatic logic [6:0] clamp_weight(input logic [6:0] w);
		logic [6:0] r;
		if (w == 7'd0) begin
			r = 7'd1;
		end else if (w > 7'(MAX_WEIGHT)) begin
			r = 7'(MAX_WEIGHT);
		end else begin
			r = w;
		end
		return r;
	endfunction

endpackage

[hdl/weighted_round_robin_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler_unit
// per-flow packet queues served in weighted round-robin order
// ----------------------------------------------------------------------------
//  channel   signals                       direction  transfer when
//  req       req_valid/req_ready/req       in         req_valid & req_ready
//  rsp       rsp_valid/rsp_ready/rsp       out        rsp_valid & rsp_ready
//  cfg       cfg_valid/cfg_ready/cfg_data  in         cfg_valid & cfg_ready
//
//  enqueue is done in the idle step; serve goes idle, skip past empty flows, then
//  read and emit per packet sent, the emit waiting on the store's registered read
//  a two-entry queue lets the front keep taking items while the back works
//  reset clears control state; the packet store and weights need no clearing
//  a stalled rsp holds the back in its idle or emit step
// ----------------------------------------------------------------------------
module weighted_round_robin_scheduler_unit import wrrs_pkg::*; #(
	parameter int NUM_FLOWS   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	// front to back command queue
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	// config is always taken
	assign cfg_ready = 1'b1;

	wrrs_front #(.NUM_FLOWS(NUM_FLOWS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop)
	);

	// back end: flow state, packet store, result register
	wrrs_back #(.NUM_FLOWS(NUM_FLOWS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[hdl/wrrs_ram.sv]
// ----------------------------------------------------------------------------
// wrrs_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wrrs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/wrrs_front.sv]
// ----------------------------------------------------------------------------
// wrrs_front
// accepts items, checks the flow slot, holds them in a two-entry queue
// ----------------------------------------------------------------------------
module wrrs_front import wrrs_pkg::*; #(
	parameter int NUM_FLOWS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic q_valid,
	output cmd_t q_cmd,
	input  logic q_pop
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cls;

	always_comb begin
		cls.req     = req;
		cls.flow_ok = ({29'd0, req.flow_index} < 32'(NUM_FLOWS));
	end

	assign req_ready = (count_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign q_valid   = (count_q != 2'd0);
	assign q_cmd     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[hdl/wrrs_back.sv]
// ----------------------------------------------------------------------------
// wrrs_back
// carries out enqueue and serve commands against the packet store
// ----------------------------------------------------------------------------
module wrrs_back import wrrs_pkg::*; #(
	parameter int NUM_FLOWS   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [6:0] cfg_data,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	localparam int FW = $clog2(NUM_FLOWS);
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = $clog2(NUM_FLOWS * QUEUE_DEPTH + 1);
	localparam int RD = NUM_FLOWS * QUEUE_DEPTH;
	localparam int AW = $clog2(RD);
	localparam int SW = HW + 2;

	back_state_t   state_q, state_d;
	logic [CW-1:0] fill_q [NUM_FLOWS];
	logic [HW-1:0] head_q [NUM_FLOWS];
	logic [6:0]    wgt_q  [NUM_FLOWS];
	logic [NUM_FLOWS-1:0] wset_q;
	logic [FW-1:0] ptr_q;
	logic [6:0]    served_q;
	logic [TW-1:0] total_q;
	logic [6:0]    dflt_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [FW+2:0] fidx_wide;
	logic [FW+2:0] ptr_wide;
	logic [FW-1:0] cur_f;
	logic [CW-1:0] cur_fill;
	logic [HW-1:0] cur_head;
	logic [6:0]    cur_w;
	logic [SW-1:0] slot_sum;
	logic [HW-1:0] slot;
	logic [HW-1:0] head_next;
	logic [FW-1:0] ptr_next;
	logic [AW-1:0] base;
	logic          out_free;
	logic          enq_ok;
	logic          last;
	logic [6:0]    new_w;

	logic          do_enq, do_drop, do_empty, do_skip, do_read, do_emit;
	logic [47:0]   ram_rdata;

	assign fidx_wide = {FW'(0), q_cmd.req.flow_index};
	assign ptr_wide  = {3'd0, ptr_q};
	assign cur_f     = (state_q == BK_IDLE) ? fidx_wide[FW-1:0] : ptr_q;
	assign cur_fill  = fill_q[cur_f];
	assign cur_head  = head_q[cur_f];
	assign cur_w     = wset_q[cur_f] ? wgt_q[cur_f] : 7'd1;
	assign slot_sum  = SW'(cur_head) + SW'(cur_fill);
	assign slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ?
	                   HW'(slot_sum - SW'(QUEUE_DEPTH)) : HW'(slot_sum);
	assign head_next = (cur_head == HW'(QUEUE_DEPTH - 1)) ? HW'(0) : cur_head + HW'(1);
	assign ptr_next  = (ptr_q == FW'(NUM_FLOWS - 1)) ? FW'(0) : ptr_q + FW'(1);
	assign base      = AW'(cur_f * QUEUE_DEPTH);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign enq_ok    = q_cmd.flow_ok && (cur_fill < CW'(QUEUE_DEPTH));
	assign last      = (cur_fill == CW'(0)) || (served_q >= cur_w);
	assign new_w     = clamp_weight((q_cmd.req.flow_weight == 7'd0) ?
	                                dflt_q : q_cmd.req.flow_weight);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free && q_cmd.req.command == CMD_SERVE
				    && total_q != TW'(0)) begin
					state_d = BK_SKIP;
				end
			end
			BK_SKIP: begin
				if (cur_fill != CW'(0)) begin
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_EMIT;
			BK_EMIT: begin
				if (out_free) begin
					state_d = last ? BK_IDLE : BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		do_enq   = 1'b0;
		do_drop  = 1'b0;
		do_empty = 1'b0;
		do_skip  = 1'b0;
		do_read  = 1'b0;
		do_emit  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					if (q_cmd.req.command == CMD_ENQUEUE) begin
						do_enq  = enq_ok;
						do_drop = !enq_ok;
					end else begin
						do_empty = (total_q == TW'(0));
					end
				end
			end
			BK_SKIP: do_skip = (cur_fill == CW'(0));
			BK_READ: do_read = 1'b1;
			BK_EMIT: do_emit = out_free;
			default: ;
		endcase
	end

	assign q_pop = do_enq || do_drop || do_empty || (do_emit && last);

	wrrs_ram #(.WIDTH(48), .DEPTH(RD)) u_store (
		.clk   (clk),
		.we    (do_enq),
		.waddr (base + AW'(slot)),
		.wdata ({q_cmd.req.packet_id, q_cmd.req.packet_length}),
		.re    (do_read),
		.raddr (base + AW'(cur_head)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (do_enq && !wset_q[cur_f]) begin
			wgt_q[cur_f] <= new_w;
		end
		if (do_enq || do_drop || do_empty) begin
			rsp_q.status      <= do_enq ? ST_ENQ : (do_drop ? ST_DROP : ST_EMPTY);
			rsp_q.sent_id     <= 32'd0;
			rsp_q.sent_length <= 16'd0;
			rsp_q.sent_flow   <= 3'd0;
			rsp_q.last_of_run <= 1'b1;
		end else if (do_emit) begin
			rsp_q.status      <= ST_SENT;
			rsp_q.sent_id     <= ram_rdata[47:16];
			rsp_q.sent_length <= ram_rdata[15:0];
			rsp_q.sent_flow   <= ptr_wide[2:0];
			rsp_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			wset_q      <= '0;
			ptr_q       <= '0;
			served_q    <= '0;
			total_q     <= '0;
			dflt_q      <= 7'd1;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FLOWS; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				dflt_q <= cfg_data;
			end
			if (do_enq) begin
				fill_q[cur_f] <= cur_fill + CW'(1);
				total_q       <= total_q + TW'(1);
				wset_q[cur_f] <= 1'b1;
			end
			if (do_empty) begin
				ptr_q    <= '0;
				served_q <= '0;
				wset_q   <= '0;
			end
			if (do_skip) begin
				ptr_q    <= ptr_next;
				served_q <= '0;
			end
			if (do_read) begin
				head_q[cur_f] <= head_next;
				fill_q[cur_f] <= cur_fill - CW'(1);
				total_q       <= total_q - TW'(1);
				served_q      <= served_q + 7'd1;
			end
			// weight used up: turn passes to the next flow
			if (do_emit && last && served_q >= cur_w) begin
				ptr_q    <= ptr_next;
				served_q <= '0;
			end
			if (do_enq || do_drop || do_empty || do_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
